/* design/lms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lms_pkg;

  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int COEF_BITS     = 24;
  localparam int COEF_FRAC     = 20;
  localparam int MU_BITS       = 16;
  localparam int MU_FRAC       = 16;
  localparam int TAP_BITS      = 6;
  localparam int INIT_ERR_BITS = 16;
  localparam int OP_BITS       = 2;
  localparam int IDX_BITS      = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INIT_ERROR = 2'd2;

  localparam logic [TAP_BITS-1:0]      TAP_COUNT_RST = 6'd32;
  localparam logic [MU_BITS-1:0]       STEP_SIZE_RST = 16'd1024;
  localparam logic [INIT_ERR_BITS-1:0] INIT_ERR_RST  = 16'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_READ,
    ST_OUT
  } state_t;

  // one tap read handed to the tap pipeline
  typedef struct packed {
    logic clear;
    logic valid;
    logic first;
  } tap_issue_t;

  typedef struct packed {
    logic upd_valid;
    logic busy;
  } tap_stat_t;

endpackage

`default_nettype wire

/* design/lms_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/lms_tap_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module lms_tap_pipe #(
  parameter int SAMPLE_BITS = lms_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_TAPS    = lms_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lms_pkg::tap_issue_t                 issue,
  input  wire logic signed [SAMPLE_BITS-1:0]       w_in,
  input  wire logic signed [lms_pkg::COEF_BITS-1:0] c_in,
  input  wire logic signed [SAMPLE_BITS-1:0]       e_in,
  input  wire logic signed [SAMPLE_BITS-1:0]       x_in,
  input  wire logic signed [SAMPLE_BITS-1:0]       d_in,
  input  wire logic [lms_pkg::MU_BITS-1:0]         mu,
  output lms_pkg::tap_stat_t                       stat,
  output logic signed [lms_pkg::COEF_BITS-1:0]     c_upd,
  output logic signed [SAMPLE_BITS-1:0]            y_out,
  output logic signed [SAMPLE_BITS-1:0]            e_out,
  output logic                                     sat_out
);

  import lms_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int TW  = 2 * SB;
  localparam int PW  = TW + MU_BITS + 1;
  localparam int SH  = 2 * (SB - 1) + MU_FRAC - COEF_FRAC;
  localparam int MW  = COEF_BITS + SB;
  localparam int ACW = MW + $clog2(MAX_TAPS + 1);

  localparam logic signed [PW-1:0]  HALF_U = PW'(longint'(1) <<< (SH - 1));
  localparam logic signed [PW-1:0]  C_HI   = PW'((longint'(1) <<< (COEF_BITS - 1)) - 1);
  localparam logic signed [PW-1:0]  C_LO   = -C_HI - PW'(1);
  localparam logic signed [ACW-1:0] HALF_Y = ACW'(longint'(1) <<< (COEF_FRAC - 1));
  localparam logic signed [ACW-1:0] S_HI   = ACW'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [ACW-1:0] S_LO   = -S_HI - ACW'(1);

  logic v1, v2, v3, v4;
  logic signed [TW-1:0]        t1;
  logic signed [COEF_BITS-1:0] c1, c2, c3;
  logic signed [SB-1:0]        wn1, wn2, wn3, w_last;
  logic signed [PW-1:0]        p2;
  logic signed [MW-1:0]        prod4;
  logic signed [ACW-1:0]       acc;
  logic                        sat_acc;

  logic signed [MU_BITS:0]     mu_s;
  logic signed [PW-1:0]        rnd, c_sum;
  logic signed [COEF_BITS-1:0] c_nx;
  logic                        c_sat;

  logic signed [ACW-1:0] y_full, e_full;
  logic                  y_sat, e_sat;

  assign mu_s = {1'b0, mu};

  always_comb begin
    rnd   = (p2 + HALF_U) >>> SH;
    c_sum = PW'(c2) + rnd;
    c_sat = 1'b0;
    if (c_sum > C_HI) begin
      c_nx  = C_HI[COEF_BITS-1:0];
      c_sat = 1'b1;
    end else if (c_sum < C_LO) begin
      c_nx  = C_LO[COEF_BITS-1:0];
      c_sat = 1'b1;
    end else begin
      c_nx = c_sum[COEF_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      acc     <= '0;
      sat_acc <= 1'b0;
    end else begin
      v1 <= issue.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (issue.clear) begin
        acc     <= '0;
        sat_acc <= 1'b0;
      end else begin
        if (v4) begin
          acc <= acc + ACW'(prod4);
        end
        if (v2 && c_sat) begin
          sat_acc <= 1'b1;
        end
      end
    end
  end

  // window entry for tap k after the shift is the old entry k-1, or x at tap 0
  always_ff @(posedge clk) begin
    t1  <= e_in * w_in;
    c1  <= c_in;
    wn1 <= issue.first ? x_in : w_last;
    if (issue.valid) begin
      w_last <= w_in;
    end
    p2    <= mu_s * t1;
    c2    <= c1;
    wn2   <= wn1;
    c3    <= c_nx;
    wn3   <= wn2;
    prod4 <= c3 * wn3;
  end

  assign stat.upd_valid = v3;
  assign stat.busy      = v1 | v2 | v3 | v4;
  assign c_upd          = c3;

  always_comb begin
    y_full = (acc + HALF_Y) >>> COEF_FRAC;
    e_full = ACW'(d_in) - y_full;
    y_sat  = 1'b0;
    e_sat  = 1'b0;
    if (y_full > S_HI) begin
      y_out = S_HI[SB-1:0];
      y_sat = 1'b1;
    end else if (y_full < S_LO) begin
      y_out = S_LO[SB-1:0];
      y_sat = 1'b1;
    end else begin
      y_out = y_full[SB-1:0];
    end
    if (e_full > S_HI) begin
      e_out = S_HI[SB-1:0];
      e_sat = 1'b1;
    end else if (e_full < S_LO) begin
      e_out = S_LO[SB-1:0];
      e_sat = 1'b1;
    end else begin
      e_out = e_full[SB-1:0];
    end
    sat_out = sat_acc | y_sat | e_sat;
  end

endmodule

`default_nettype wire

/* design/lms_adaptive_fir.sv */
`timescale 1ns / 1ps
`default_nettype none

// LMS adaptive FIR filter.
// Input channel s_axis_*: tuser holds op (sample, coefficient write, coefficient
// read), tlast marks the last sample of a block. Output channel m_axis_*: one
// result item per input item; tlast is block_done, tuser is the saturation flag.
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_data): tap count,
// step size and initial error.
// Sample items: one pass over the active taps reads coefficient and window
// memories once per tap, adapts each coefficient and accumulates the output in a
// multiply pipeline. With no active taps the pass is skipped. The next item is
// taken in the cycle after the result is loaded into the output register.
// Coefficient write items go straight to the output state; read items pass
// through a coefficient read state first.
// One item is processed at a time; the output register lets a new item be
// accepted while the previous result waits. If the receiver stalls, the next
// result waits in the block until the output register frees up.
// Reset (rst, synchronous) restores the register defaults; the delay line and
// coefficients read as zero through a fill count and per-entry valid flags, so
// no clearing pass is needed and the block is ready the cycle after reset.
module lms_adaptive_fir #(
  parameter int MAX_TAPS    = lms_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = lms_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + lms_pkg::IDX_BITS + lms_pkg::COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + lms_pkg::COEF_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lms_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [lms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample_in, desired_in, coeff_index, coeff_value
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  // op
  input  wire logic [lms_pkg::OP_BITS-1:0]       s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // filtered_out, error_out, coeff_read
  output logic [OUT_W-1:0]                       m_axis_tdata,
  // saturated
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast
);

  import lms_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(MAX_TAPS);
  localparam int AW1 = AW + 1;
  localparam int KW  = $clog2(MAX_TAPS + 1);
  localparam int EW  = (SB > INIT_ERR_BITS) ? SB : INIT_ERR_BITS;

  localparam logic signed [EW-1:0] S_HI = EW'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [EW-1:0] S_LO = -S_HI - EW'(1);

  state_t state, state_next;

  logic [TAP_BITS-1:0]      tap_count;
  logic [MU_BITS-1:0]       step_size;
  logic [INIT_ERR_BITS-1:0] init_err;

  logic signed [SB-1:0]        in_x, in_d;
  logic [IDX_BITS-1:0]         in_idx;
  logic signed [COEF_BITS-1:0] in_cval;
  logic [OP_BITS-1:0]          in_op;
  logic                        in_fire, in_ready, idx_ok;
  logic [AW-1:0]               idx_a;
  logic [KW-1:0]               taps_eff;

  logic signed [SB-1:0] x_q, d_q, last_err;
  logic                 eob_q;
  logic [KW-1:0]        tq, k, fill;
  logic [AW-1:0]        p, p_next, wk;
  logic [AW1-1:0]       wa;
  logic [MAX_TAPS-1:0]  cvld;
  logic                 run_issue, issue_q_valid, issue_q_first, w_ok_q, c_ok_q, rd_ok_q;

  logic                 c_we;
  logic [AW-1:0]        c_waddr, c_raddr;
  logic [COEF_BITS-1:0] c_wdata, c_rdata;
  logic [SB-1:0]        w_rdata;

  tap_issue_t                  issue;
  tap_stat_t                   stat;
  logic signed [SB-1:0]        w_in, fin_y, fin_e;
  logic signed [COEF_BITS-1:0] c_in, c_upd;
  logic                        fin_sat;

  logic signed [EW-1:0] ie_ext;
  logic signed [SB-1:0] ie_sat;

  logic signed [SB-1:0]        res_y, res_e, o_y, o_e;
  logic signed [COEF_BITS-1:0] res_coef, o_coef;
  logic                        res_done, res_sat, o_done, o_sat, m_valid, out_free, load;

  assign in_x    = s_axis_tdata[SB-1:0];
  assign in_d    = s_axis_tdata[2*SB-1:SB];
  assign in_idx  = s_axis_tdata[2*SB+IDX_BITS-1:2*SB];
  assign in_cval = s_axis_tdata[2*SB+IDX_BITS+COEF_BITS-1:2*SB+IDX_BITS];
  assign in_op   = s_axis_tuser;

  assign in_fire  = s_axis_tvalid && in_ready;
  assign idx_ok   = 32'(in_idx) < 32'(MAX_TAPS);
  assign idx_a    = AW'(in_idx);
  assign taps_eff = (32'(tap_count) > 32'(MAX_TAPS)) ? KW'(MAX_TAPS) : KW'(tap_count);

  assign out_free = !m_valid || m_axis_tready;
  assign load     = (state == ST_OUT) && out_free;

  // tap k of the window sits k entries behind the newest one
  assign wa = ({1'b0, p} >= AW1'(k)) ? {1'b0, p} - AW1'(k)
                                     : {1'b0, p} + AW1'(MAX_TAPS) - AW1'(k);
  assign p_next = (p == AW'(MAX_TAPS - 1)) ? '0 : p + 1'b1;

  assign ie_ext = EW'($signed(init_err));
  assign ie_sat = (ie_ext > S_HI) ? S_HI[SB-1:0] :
                  (ie_ext < S_LO) ? S_LO[SB-1:0] : ie_ext[SB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    run_issue  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          case (in_op)
            OP_SAMPLE: state_next = (taps_eff == '0) ? ST_FINISH : ST_RUN;
            OP_READ:   state_next = ST_READ;
            default:   state_next = ST_OUT;
          endcase
        end
      end
      ST_RUN: begin
        run_issue = 1'b1;
        if (KW'(k + 1'b1) == tq) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!issue_q_valid && !stat.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_OUT;
      ST_READ:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RST;
      step_size <= STEP_SIZE_RST;
      init_err  <= INIT_ERR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TAP_COUNT:  tap_count <= cfg_data[TAP_BITS-1:0];
        CFG_STEP_SIZE:  step_size <= cfg_data[MU_BITS-1:0];
        CFG_INIT_ERROR: init_err  <= cfg_data[INIT_ERR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err      <= '0;
      p             <= '0;
      fill          <= '0;
      cvld          <= '0;
      k             <= '0;
      wk            <= '0;
      issue_q_valid <= 1'b0;
    end else begin
      issue_q_valid <= run_issue;
      if (in_fire && in_op == OP_SAMPLE) begin
        k  <= '0;
        wk <= '0;
      end else if (run_issue) begin
        k <= k + 1'b1;
      end
      if (stat.upd_valid) begin
        cvld[wk] <= 1'b1;
        wk       <= wk + 1'b1;
      end
      if (in_fire && in_op == OP_WRITE && idx_ok) begin
        cvld[idx_a] <= 1'b1;
      end
      if (state == ST_FINISH) begin
        last_err <= eob_q ? ie_sat : fin_e;
        p        <= p_next;
        if (fill != KW'(MAX_TAPS)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_q_first <= (k == '0);
    w_ok_q        <= (k < fill);
    c_ok_q        <= cvld[k[AW-1:0]];
    if (in_fire) begin
      x_q      <= in_x;
      d_q      <= in_d;
      eob_q    <= s_axis_tlast;
      tq       <= taps_eff;
      rd_ok_q  <= idx_ok && cvld[idx_a];
      res_y    <= '0;
      res_e    <= '0;
      res_done <= 1'b0;
      res_sat  <= 1'b0;
      res_coef <= (in_op == OP_WRITE) ? in_cval : '0;
    end
    if (state == ST_FINISH) begin
      res_y    <= fin_y;
      res_e    <= fin_e;
      res_done <= eob_q;
      res_sat  <= fin_sat;
    end
    if (state == ST_READ) begin
      res_coef <= rd_ok_q ? c_rdata : '0;
    end
    if (load) begin
      o_y    <= res_y;
      o_e    <= res_e;
      o_done <= res_done;
      o_coef <= res_coef;
      o_sat  <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  assign c_we    = stat.upd_valid || (in_fire && in_op == OP_WRITE && idx_ok);
  assign c_waddr = stat.upd_valid ? wk : idx_a;
  assign c_wdata = stat.upd_valid ? c_upd : in_cval;
  assign c_raddr = (state == ST_RUN) ? k[AW-1:0] : idx_a;

  lms_ram #(
    .WIDTH(COEF_BITS),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(c_wdata),
    .raddr(c_raddr),
    .rdata(c_rdata)
  );

  lms_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_TAPS)
  ) u_win_ram (
    .clk  (clk),
    .we   (state == ST_FINISH),
    .waddr(p_next),
    .wdata(x_q),
    .raddr(wa[AW-1:0]),
    .rdata(w_rdata)
  );

  assign issue.clear = in_fire && in_op == OP_SAMPLE;
  assign issue.valid = issue_q_valid;
  assign issue.first = issue_q_first;
  assign w_in        = w_ok_q ? w_rdata : '0;
  assign c_in        = c_ok_q ? c_rdata : '0;

  lms_tap_pipe #(
    .SAMPLE_BITS(SB),
    .MAX_TAPS   (MAX_TAPS)
  ) u_pipe (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .w_in   (w_in),
    .c_in   (c_in),
    .e_in   (last_err),
    .x_in   (x_q),
    .d_in   (d_q),
    .mu     (step_size),
    .stat   (stat),
    .c_upd  (c_upd),
    .y_out  (fin_y),
    .e_out  (fin_e),
    .sat_out(fin_sat)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_W'({o_coef, o_e, o_y});
  assign m_axis_tuser  = o_sat;
  assign m_axis_tlast  = o_done;

endmodule

`default_nettype wire

/* design/lms_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lms_checker #(
  parameter int SAMPLE_BITS = lms_pkg::SAMPLE_BITS_DEF,
  parameter int OUT_W       = ((2 * SAMPLE_BITS + lms_pkg::COEF_BITS + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tuser,
  input wire logic             m_axis_tlast
);

  import lms_pkg::*;

  logic [COEF_BITS-1:0] coef_field;

  assign coef_field = m_axis_tdata[2*SAMPLE_BITS +: COEF_BITS];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item valid after reset");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_coef_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (coef_field != '0) |-> !m_axis_tuser && !m_axis_tlast)
    else $error("coefficient result carries sample flags");

endmodule

bind lms_adaptive_fir lms_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .OUT_W      (OUT_W)
) u_lms_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

/* dv/lms_fir_checker.sv */
`timescale 1ns / 1ps

module lms_fir_checker
  import lms_pkg::*;
#(
  parameter int IN_W  = 64,
  parameter int OUT_W = 56
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     s_axis_tvalid,
  input  wire logic                     s_axis_tready,
  // sample_in, desired_in, coeff_index, coeff_value
  input  wire logic [IN_W-1:0]          s_axis_tdata,
  // op
  input  wire logic [OP_BITS-1:0]       s_axis_tuser,
  input  wire logic                     s_axis_tlast,
  input  wire logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // filtered_out, error_out, coeff_read
  input  wire logic [OUT_W-1:0]         m_axis_tdata,
  // saturated
  input  wire logic                     m_axis_tuser,
  input  wire logic                     m_axis_tlast,
  output int                            fail_count,
  output int                            results_due
);

  localparam int SB        = SAMPLE_BITS_DEF;
  localparam int NT        = MAX_TAPS_DEF;
  localparam int UPD_SHIFT = 2 * (SB - 1) + MU_FRAC - COEF_FRAC;

  typedef struct packed {
    logic signed [SB-1:0]        filtered;
    logic signed [SB-1:0]        err;
    logic                        done;
    logic signed [COEF_BITS-1:0] coeff;
    logic                        sat;
  } fir_result_t;

  logic signed [SB-1:0]            window [NT];
  logic signed [COEF_BITS-1:0]     coeffs [NT];
  logic signed [SB-1:0]            err_prev;
  logic [TAP_BITS-1:0]             tap_count_q;
  logic [MU_BITS-1:0]              step_q;
  logic signed [INIT_ERR_BITS-1:0] init_err_q;
  logic                            clip_hit;
  fir_result_t                     awaited [$];
  int                              results_seen;

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) begin
      clip_hit = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      clip_hit = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  // adapts with the old window and old error, then shifts and filters
  function automatic fir_result_t predict_response(input logic [OP_BITS-1:0] op,
                                                   input logic [IN_W-1:0] data,
                                                   input logic eob);
    fir_result_t                 r;
    logic signed [SB-1:0]        x;
    logic signed [SB-1:0]        d;
    logic [IDX_BITS-1:0]         idx;
    logic signed [COEF_BITS-1:0] cval;
    longint                      acc;
    longint                      upd;
    longint                      y;
    int                          taps;
    int                          k;
    x    = data[SB-1:0];
    d    = data[2*SB-1:SB];
    idx  = data[2*SB +: IDX_BITS];
    cval = data[2*SB+IDX_BITS +: COEF_BITS];
    r = '0;
    clip_hit = 1'b0;
    case (op)
      OP_SAMPLE: begin
        taps = (int'(tap_count_q) > NT) ? NT : int'(tap_count_q);
        for (k = 0; k < taps; k++) begin
          upd = (longint'(step_q) * (longint'(err_prev) * longint'(window[k]))
                 + (longint'(1) <<< (UPD_SHIFT - 1))) >>> UPD_SHIFT;
          coeffs[k] = COEF_BITS'(clip(longint'(coeffs[k]) + upd, COEF_BITS));
        end
        for (k = NT - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = x;
        acc = 0;
        for (k = 0; k < taps; k++) acc += longint'(coeffs[k]) * longint'(window[k]);
        y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        r.filtered = SB'(clip(y, SB));
        r.err      = SB'(clip(longint'(d) - y, SB));
        r.done     = eob;
        r.sat      = clip_hit;
        err_prev   = eob ? init_err_q : r.err;
      end
      OP_WRITE: begin
        coeffs[idx] = cval;
        r.coeff = cval;
      end
      OP_READ: begin
        r.coeff = coeffs[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 100) $display("%0t: result %0d: %s", $time, results_seen, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    fir_result_t want;
    fir_result_t got;
    int n;
    if (rst) begin
      for (n = 0; n < NT; n++) begin
        window[n] = '0;
        coeffs[n] = '0;
      end
      err_prev     = '0;
      tap_count_q  = TAP_COUNT_RST;
      step_q       = STEP_SIZE_RST;
      init_err_q   = INIT_ERR_RST;
      awaited.delete();
      results_seen = 0;
      fail_count   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TAP_COUNT:  tap_count_q = cfg_data[TAP_BITS-1:0];
          CFG_STEP_SIZE:  step_q      = cfg_data[MU_BITS-1:0];
          CFG_INIT_ERROR: init_err_q  = cfg_data[INIT_ERR_BITS-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.filtered = m_axis_tdata[SB-1:0];
        got.err      = m_axis_tdata[2*SB-1:SB];
        got.coeff    = m_axis_tdata[2*SB +: COEF_BITS];
        got.done     = m_axis_tlast;
        got.sat      = m_axis_tuser;
        if (awaited.size() == 0) begin
          report_mismatch("result arrived with no item pending");
        end else begin
          want = awaited.pop_front();
          if (got.filtered !== want.filtered)
            report_mismatch($sformatf("filtered_out %0d, expected %0d",
                                      got.filtered, want.filtered));
          if (got.err !== want.err)
            report_mismatch($sformatf("error_out %0d, expected %0d", got.err, want.err));
          if (got.done !== want.done)
            report_mismatch($sformatf("block_done %0b, expected %0b", got.done, want.done));
          if (got.coeff !== want.coeff)
            report_mismatch($sformatf("coeff_read %0d, expected %0d",
                                      got.coeff, want.coeff));
          if (got.sat !== want.sat)
            report_mismatch($sformatf("saturated %0b, expected %0b", got.sat, want.sat));
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited.push_back(predict_response(s_axis_tuser, s_axis_tdata, s_axis_tlast));
    end
    results_due = awaited.size();
  end

endmodule

/* dv/tb_lms_adaptive_fir.sv */
`timescale 1ns / 1ps

module tb_lms_adaptive_fir;
  import lms_pkg::*;

  localparam int SB              = SAMPLE_BITS_DEF;
  localparam int IN_W            = ((2 * SB + IDX_BITS + COEF_BITS + 7) / 8) * 8;
  localparam int OUT_W           = ((2 * SB + COEF_BITS + 7) / 8) * 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS     = 130;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_W-1:0]          s_axis_tdata = '0;
  logic [OP_BITS-1:0]       s_axis_tuser = '0;
  logic                     s_axis_tlast = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_W-1:0]         m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;

  int   fail_count;
  int   results_due;
  int   burst_left = 0;
  int   gap_max = 3;
  int   rx_mode = 1;
  logic hold_off_req = 1'b0;

  lms_adaptive_fir uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lms_fir_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input logic [OP_BITS-1:0] op, input logic [SB-1:0] x,
                           input logic [SB-1:0] d, input logic eob,
                           input logic [IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      repeat ($urandom_range(0, gap_max)) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_W'({c, idx, d, x});
    s_axis_tuser  = op;
    s_axis_tlast  = eob;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // blocks of samples closed by an end mark, with coefficient traffic mixed in
  task automatic run_random(input int count);
    int                    i;
    int                    roll;
    int                    block_left;
    int                    shift;
    logic signed [SB-1:0]  x;
    logic signed [SB-1:0]  d;
    logic [COEF_BITS-1:0]  c;
    block_left = $urandom_range(1, 24);
    shift = $urandom_range(0, 8);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) drain();
      roll = $urandom_range(0, 99);
      x = $signed(SB'($urandom)) >>> shift;
      d = $signed(SB'($urandom)) >>> shift;
      c = $signed(COEF_BITS'($urandom)) >>> $urandom_range(0, 12);
      if (roll < 8) begin
        send_item(OP_WRITE, x, d, 1'($urandom), IDX_BITS'($urandom), c);
      end else if (roll < 16) begin
        send_item(OP_READ, x, d, 1'($urandom), IDX_BITS'($urandom), c);
      end else if (roll < 19) begin
        send_item(OP_UNUSED, x, d, 1'($urandom), IDX_BITS'($urandom), c);
      end else begin
        block_left--;
        send_item(OP_SAMPLE, x, d, block_left == 0, IDX_BITS'($urandom), c);
        if (block_left == 0) begin
          block_left = $urandom_range(1, 24);
          shift = $urandom_range(0, 8);
        end
      end
    end
  endtask

  initial begin : receiver
    int run;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (rx_mode == 0) begin
        m_axis_tready = 1'b1;
        @(negedge clk);
      end else begin
        run = $urandom_range(1, 6);
        m_axis_tready = ($urandom_range(0, 2) != 0);
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [TAP_BITS-1:0]      taps;
    logic [MU_BITS-1:0]       mu;
    logic [INIT_ERR_BITS-1:0] ierr;
    int                       p;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: coefficient extremes, unused op, sample extremes
    send_item(OP_READ,   16'h0000, 16'h0000, 1'b0, 5'd0,  24'h000000);
    send_item(OP_WRITE,  16'h1234, 16'h4321, 1'b1, 5'd0,  24'h7FFFFF);
    send_item(OP_WRITE,  16'h0000, 16'h0000, 1'b0, 5'd31, 24'h800000);
    send_item(OP_READ,   16'hFFFF, 16'hFFFF, 1'b1, 5'd31, 24'hFFFFFF);
    send_item(OP_UNUSED, 16'h7FFF, 16'h8000, 1'b1, 5'd31, 24'h7FFFFF);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, 5'd31, 24'hFFFFFF);
    send_item(OP_SAMPLE, 16'h8000, 16'h7FFF, 1'b0, 5'd0,  24'h000000);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b0, 5'd0,  24'h000000);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 1'b1, 5'd0,  24'h000000);
    send_item(OP_SAMPLE, 16'hFFFF, 16'h0001, 1'b0, 5'd0,  24'h000000);
    send_item(OP_READ,   16'h0000, 16'h0000, 1'b0, 5'd0,  24'h000000);
    drain();

    // one tap, full step, most negative reload: coefficient clips high
    cfg_write(CFG_TAP_COUNT,  16'd1);
    cfg_write(CFG_STEP_SIZE,  16'hFFFF);
    cfg_write(CFG_INIT_ERROR, 16'h8000);
    send_item(OP_WRITE,  16'h0000, 16'h0000, 1'b0, 5'd0, 24'h7FFFFF);
    send_item(OP_SAMPLE, 16'h8000, 16'h7FFF, 1'b1, 5'd0, 24'h000000);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, 5'd0, 24'h000000);
    send_item(OP_READ,   16'h0000, 16'h0000, 1'b0, 5'd0, 24'h000000);
    drain();

    // no active taps
    cfg_write(CFG_TAP_COUNT, 16'd0);
    send_item(OP_SAMPLE, 16'h4000, 16'h2000, 1'b0, 5'd3, 24'h000000);
    send_item(OP_SAMPLE, 16'hC000, 16'h8000, 1'b1, 5'd3, 24'h000000);
    drain();

    // tap count above the maximum
    cfg_write(CFG_TAP_COUNT, 16'd63);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h0100, 1'b0, 5'd0, 24'h000000);
    send_item(OP_SAMPLE, 16'h8000, 16'hFF00, 1'b1, 5'd0, 24'h000000);
    drain();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin taps = 6'd32; mu = 16'd1024;  ierr = 16'd0;    end
        1: begin taps = 6'd1;  mu = 16'hFFFF;  ierr = 16'h7FFF; end
        2: begin taps = 6'd0;  mu = 16'd500;   ierr = 16'h8000; end
        3: begin taps = 6'd63; mu = 16'd4096;  ierr = 16'hFF9C; end
        4: begin taps = 6'd16; mu = 16'd0;     ierr = 16'd12345; end
        7: begin taps = 6'd2;  mu = 16'd20000; ierr = 16'hF000; end
        default: begin
          taps = TAP_BITS'($urandom_range(1, 32));
          mu   = MU_BITS'($urandom);
          ierr = INIT_ERR_BITS'($urandom);
        end
      endcase
      drain();
      cfg_write(CFG_TAP_COUNT,  CFG_DATA_BITS'(taps));
      cfg_write(CFG_STEP_SIZE,  mu);
      cfg_write(CFG_INIT_ERROR, ierr);
      gap_max = (p % 3 == 2) ? 0 : 8;
      rx_mode = (p % 3 == 2) ? 0 : 1;
      if (p == 1) hold_off_req = 1'b1;
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
